// ===== rtl/cabps_pkg.sv =====
package cabps_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int CFG_WIDTH  = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int COORD_W    = 16;
    localparam int PIXEL_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

    localparam logic [CFG_WIDTH-1:0] CANVAS_RESET = 9'd256;

    // item kinds
    localparam logic ACTION_DRAW = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    // result codes
    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOB  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SKIP = 2'd2;

    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // floor(x / 255), exact for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== rtl/cabps_frame_mem.sv =====
module cabps_frame_mem
    import cabps_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
    parameter int AW    = 16
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [PIXEL_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [PIXEL_W-1:0] rd_data
);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cabps_blend.sv =====
module cabps_blend
    import cabps_pkg::*;
(
    input  logic               aclk,
    input  logic               load,
    input  logic [PIXEL_W-1:0] old_pixel,
    input  logic [PIXEL_W-1:0] new_pixel,
    output logic [PIXEL_W-1:0] blend_pixel
);

    // per channel: old*(255-a) and new*a, summed and divided next cycle
    logic [15:0] p_old_reg [3];
    logic [15:0] p_new_reg [3];
    logic [7:0]  alpha_reg;
    logic [7:0]  alpha;
    logic [7:0]  inv_alpha;
    logic [7:0]  chan [3];

    assign alpha     = new_pixel[31:24];
    assign inv_alpha = ALPHA_OPAQUE - alpha;

    always_ff @(posedge aclk) begin
        if (load) begin
            alpha_reg <= alpha;
            for (int c = 0; c < 3; c++) begin
                p_old_reg[c] <= old_pixel[8*c +: 8] * inv_alpha;
                p_new_reg[c] <= new_pixel[8*c +: 8] * alpha;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            chan[c] = div255(p_old_reg[c] + p_new_reg[c]);
        end
    end

    assign blend_pixel = {alpha_reg, chan[2], chan[1], chan[0]};

endmodule

// ===== rtl/clipped_alpha_blend_pixel_store.sv =====
// One item is in flight at a time: a new item is taken only in IDLE, after
// the last has left write-back. The walk is address multiply, memory read,
// blend multiply stage, then the divide/write-back stage, which waits while
// the output register holds a result that has not been taken.
// Reset: aresetn synchronous, active low; clears control and sets both canvas
// registers to 256. The frame store is not cleared: entries read as garbage
// until written.
module clipped_alpha_blend_pixel_store
    import cabps_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_WIDTH-1:0] cfg_wr_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // x_coord[15:0], y_coord[31:16], pixel_value[63:32]
    input  logic                 s_tuser,   // action
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // read_pixel[31:0], status[33:32], zero[39:34]
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW_RAW = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)
                          ? $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int CW     = (CW_RAW > CFG_WIDTH) ? CW_RAW : CFG_WIDTH;
    localparam int PW     = YW + CW + 1;

    // One-hot sequencer: IDLE takes an item, ADDR forms y*w+x, RDREQ issues
    // the memory read, BLEND registers the channel products, WB writes back
    // and hands the result to the output register.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ADDR  = 5'b00010,
        ST_RDREQ = 5'b00100,
        ST_BLEND = 5'b01000,
        ST_WB    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // canvas registers
    logic [CFG_WIDTH-1:0] width_reg, width_next;
    logic [CFG_WIDTH-1:0] height_reg, height_next;
    logic [CW-1:0]        w_sat, h_sat;

    // item held while it is worked on
    logic               act_reg;
    logic               inb_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [PIXEL_W-1:0] pix_reg;
    logic [AW-1:0]      addr_reg;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;

    logic               s_accept;
    logic               out_free;
    logic               wb_go;
    logic               x_in, y_in;
    logic [COORD_W-1:0] x_in_c, y_in_c;
    logic [PW-1:0]      addr_calc;
    logic [7:0]         alpha;
    logic               do_write;
    logic [PIXEL_W-1:0] mem_rdata;
    logic [PIXEL_W-1:0] blend_pix;
    logic [PIXEL_W-1:0] wr_pix;
    logic [PIXEL_W-1:0] res_pixel;
    logic [STATUS_W-1:0] res_status;

    // Register values above the store's limits saturate, so addresses stay
    // inside the memory.
    assign w_sat = (CW'(width_reg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_reg);
    assign h_sat = (CW'(height_reg) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_reg);

    // Clipping on the incoming coordinates; negatives are out straight away.
    assign x_in_c = s_tdata[15:0];
    assign y_in_c = s_tdata[31:16];
    assign x_in   = !x_in_c[15] && (x_in_c < COORD_W'(w_sat));
    assign y_in   = !y_in_c[15] && (y_in_c < COORD_W'(h_sat));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign wb_go    = (state_reg == ST_WB) && out_free;

    assign addr_calc = PW'(y_reg) * PW'(w_sat) + PW'(x_reg);

    assign alpha    = pix_reg[31:24];
    assign do_write = wb_go && (act_reg == ACTION_DRAW) && inb_reg && (alpha != ALPHA_CLEAR);
    assign wr_pix   = (alpha == ALPHA_OPAQUE) ? pix_reg : blend_pix;

    cabps_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (do_write),
        .wr_addr (addr_reg),
        .wr_data (wr_pix),
        .rd_en   (state_reg == ST_RDREQ),
        .rd_addr (addr_reg),
        .rd_data (mem_rdata)
    );

    cabps_blend u_blend (
        .aclk        (aclk),
        .load        (state_reg == ST_BLEND),
        .old_pixel   (mem_rdata),
        .new_pixel   (pix_reg),
        .blend_pixel (blend_pix)
    );

    // Result: read data only for an in-bounds read; read data stays in the
    // memory's output register until the next item's read.
    always_comb begin
        res_pixel = '0;
        if (act_reg == ACTION_READ && inb_reg) begin
            res_pixel = mem_rdata;
        end
        priority if (!inb_reg) begin
            res_status = STATUS_OOB;
        end else if (act_reg == ACTION_DRAW && alpha == ALPHA_CLEAR) begin
            res_status = STATUS_SKIP;
        end else begin
            res_status = STATUS_DONE;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) begin
                state_next = ST_ADDR;
            end
            ST_ADDR:  state_next = ST_RDREQ;
            ST_RDREQ: state_next = ST_BLEND;
            ST_BLEND: state_next = ST_WB;
            ST_WB:    if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CANVAS_WIDTH:  width_next  = cfg_wr_data;
                REG_CANVAS_HEIGHT: height_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (wb_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= CANVAS_RESET;
            height_reg  <= CANVAS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg <= s_tuser;
            inb_reg <= x_in && y_in;
            x_reg   <= x_in_c[XW-1:0];
            y_reg   <= y_in_c[YW-1:0];
            pix_reg <= s_tdata[63:32];
        end
        if (state_reg == ST_ADDR) begin
            addr_reg <= addr_calc[AW-1:0];
        end
        if (wb_go) begin
            m_data_reg <= {{(M_DATA_W - PIXEL_W - STATUS_W){1'b0}}, res_status, res_pixel};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // sequencer stays one-hot
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // only one item in flight: after an accept nothing is taken until write-back
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("item accepted while another is in flight");

    // the store is written only for in-bounds, non-transparent draws
    a_write_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |-> (inb_reg && act_reg == ACTION_DRAW && pix_reg[31:24] != ALPHA_CLEAR))
        else $error("frame store written for a non-drawing item");

    // an out-of-bounds result never carries pixel data
    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[33:32] == STATUS_OOB) |-> (m_data_reg[31:0] == '0))
        else $error("out-of-bounds result with non-zero pixel");

endmodule
